/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, active during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rip_pkg.sv */
// Package with the item types, codes and constants of the radix integer parser.
`timescale 1ns / 1ps

package rip_pkg;

   // One character of the text.
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
      logic       text_empty;
   } req_item_type;

   // One parse result.
   typedef struct packed {
      logic [63:0] parsed_value;
      logic [1:0]  parse_status;
   } rsp_item_type;

   typedef logic [2:0] radix_mode_type;

   localparam radix_mode_type MODE_AUTO = 3'd0;
   localparam radix_mode_type MODE_BIN  = 3'd1;
   localparam radix_mode_type MODE_OCT  = 3'd2;
   localparam radix_mode_type MODE_DEC  = 3'd3;
   localparam radix_mode_type MODE_HEX  = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FAIL     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [1:0] {
      RADIX_2,
      RADIX_8,
      RADIX_10,
      RADIX_16
   } radix_type;

   typedef enum logic [1:0] {
      POS_START,
      POS_HELD,
      POS_DECIDED
   } position_type;

   localparam logic [6:0] COUNT_MAX = 7'd64;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LOW_B = 8'h62;
   localparam logic [7:0] CHAR_LOW_O = 8'h6f;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;

   // Running state of the text being parsed.
   typedef struct packed {
      logic [63:0]  accumulator;
      logic [7:0]   held_first_char;
      position_type char_position;
      logic [6:0]   digit_count;
      radix_type    effective_radix;
      logic         failed_flag;
   } text_state_type;

endpackage

/* hw/rtl/rip_step.sv */
// Combinational parse step: next text state and result for one character item.
`timescale 1ns / 1ps

module rip_step (
   input  rip_pkg::radix_mode_type radix_mode,
   input  rip_pkg::text_state_type cur_state,
   input  rip_pkg::req_item_type   item,
   output rip_pkg::text_state_type next_state,
   output rip_pkg::rsp_item_type   result,
   output logic                    result_valid
);

   typedef struct packed {
      logic               strip;
      rip_pkg::radix_type radix;
      logic               fail;
   } decision_type;

   // Returns {valid, digit} for character c in radix r.
   function automatic logic [4:0] digit_of(logic [7:0] c, rip_pkg::radix_type r);
      logic [3:0] d;
      logic       ok;
      logic       in_range;
      d = 4'd0;
      ok = 1'b1;
      if (c >= rip_pkg::CHAR_ZERO && c <= rip_pkg::CHAR_NINE) begin
         d = c[3:0];
      end else if (c >= rip_pkg::CHAR_LOW_A && c <= rip_pkg::CHAR_LOW_F) begin
         d = c[3:0] + 4'd9;
      end else if (c >= rip_pkg::CHAR_UP_A && c <= rip_pkg::CHAR_UP_F) begin
         d = c[3:0] + 4'd9;
      end else begin
         ok = 1'b0;
      end
      unique case (r)
         rip_pkg::RADIX_2:  in_range = (d < 4'd2);
         rip_pkg::RADIX_8:  in_range = (d < 4'd8);
         rip_pkg::RADIX_10: in_range = (d < 4'd10);
         rip_pkg::RADIX_16: in_range = 1'b1;
      endcase
      return {ok & in_range, d};
   endfunction

   // Multiplication by the radix: shifts, and shift-and-add for ten.
   function automatic logic [63:0] scale(logic [63:0] acc, rip_pkg::radix_type r);
      logic [63:0] s;
      unique case (r)
         rip_pkg::RADIX_2:  s = {acc[62:0], 1'b0};
         rip_pkg::RADIX_8:  s = {acc[60:0], 3'b000};
         rip_pkg::RADIX_10: s = {acc[60:0], 3'b000} + {acc[62:0], 1'b0};
         rip_pkg::RADIX_16: s = {acc[59:0], 4'b0000};
      endcase
      return s;
   endfunction

   function automatic logic [6:0] digit_limit(rip_pkg::radix_type r);
      logic [6:0] lim;
      unique case (r)
         rip_pkg::RADIX_2:  lim = 7'd63;
         rip_pkg::RADIX_8:  lim = 7'd21;
         rip_pkg::RADIX_10: lim = 7'd19;
         rip_pkg::RADIX_16: lim = 7'd16;
      endcase
      return lim;
   endfunction

   function automatic decision_type decide(rip_pkg::radix_mode_type mode, logic have_second,
                                           logic [7:0] first, logic [7:0] second);
      decision_type dec;
      logic         zero_lead;
      zero_lead = have_second && (first == rip_pkg::CHAR_ZERO);
      dec = '{strip: 1'b0, radix: rip_pkg::RADIX_10, fail: 1'b0};
      unique case (mode)
         rip_pkg::MODE_AUTO: begin
            if (zero_lead && second == rip_pkg::CHAR_LOW_B) begin
               dec.strip = 1'b1;
               dec.radix = rip_pkg::RADIX_2;
            end else if (zero_lead && second == rip_pkg::CHAR_LOW_O) begin
               dec.strip = 1'b1;
               dec.radix = rip_pkg::RADIX_8;
            end else if (zero_lead && second == rip_pkg::CHAR_LOW_X) begin
               dec.strip = 1'b1;
               dec.radix = rip_pkg::RADIX_16;
            end
         end
         rip_pkg::MODE_BIN: begin
            dec.radix = rip_pkg::RADIX_2;
            dec.strip = zero_lead && (second == rip_pkg::CHAR_LOW_B);
         end
         rip_pkg::MODE_OCT: begin
            dec.radix = rip_pkg::RADIX_8;
            dec.strip = zero_lead && (second == rip_pkg::CHAR_LOW_O);
         end
         rip_pkg::MODE_DEC: begin
            dec.radix = rip_pkg::RADIX_10;
         end
         rip_pkg::MODE_HEX: begin
            dec.radix = rip_pkg::RADIX_16;
            dec.strip = zero_lead && (second == rip_pkg::CHAR_LOW_X);
         end
         default: begin
            dec.fail = 1'b1;
         end
      endcase
      return dec;
   endfunction

   // The held first character is always the first digit, so the accumulator is still zero.
   function automatic rip_pkg::text_state_type feed_held(rip_pkg::text_state_type s);
      rip_pkg::text_state_type r;
      logic [4:0]              dig;
      r = s;
      dig = digit_of(s.held_first_char, s.effective_radix);
      if (!s.failed_flag) begin
         if (!dig[4]) begin
            r.failed_flag = 1'b1;
         end else begin
            r.accumulator = {60'd0, dig[3:0]};
            r.digit_count = 7'd1;
         end
      end
      return r;
   endfunction

   function automatic rip_pkg::text_state_type feed_char(rip_pkg::text_state_type s,
                                                         logic [7:0] c);
      rip_pkg::text_state_type r;
      logic [4:0]              dig;
      r = s;
      dig = digit_of(c, s.effective_radix);
      if (!s.failed_flag) begin
         if (!dig[4]) begin
            r.failed_flag = 1'b1;
         end else begin
            r.accumulator = scale(s.accumulator, s.effective_radix) + {60'd0, dig[3:0]};
            if (s.digit_count < rip_pkg::COUNT_MAX) begin
               r.digit_count = s.digit_count + 7'd1;
            end
         end
      end
      return r;
   endfunction

   rip_pkg::text_state_type st;
   decision_type            dec_second;
   decision_type            dec_end;
   logic                    do_feed;
   logic                    end_text;
   logic [1:0]              status;

   always_comb begin
      st = cur_state;
      do_feed = 1'b0;
      dec_second = decide(radix_mode, 1'b1, cur_state.held_first_char, item.char_code);
      if (!item.text_empty) begin
         unique case (st.char_position)
            rip_pkg::POS_START: begin
               st.held_first_char = item.char_code;
               st.char_position = rip_pkg::POS_HELD;
            end
            rip_pkg::POS_HELD: begin
               st.effective_radix = dec_second.radix;
               st.failed_flag = st.failed_flag | dec_second.fail;
               st.char_position = rip_pkg::POS_DECIDED;
               if (!dec_second.strip) begin
                  st = feed_held(st);
                  do_feed = 1'b1;
               end
            end
            rip_pkg::POS_DECIDED: begin
               do_feed = 1'b1;
            end
            default: begin
               st = cur_state;
            end
         endcase
      end
      if (do_feed) begin
         st = feed_char(st, item.char_code);
      end

      end_text = item.text_empty | item.last_char;
      dec_end = decide(radix_mode, 1'b0, st.held_first_char, 8'd0);
      // A text of one character decides its base only here, at its end.
      if (end_text && st.char_position == rip_pkg::POS_HELD) begin
         st.effective_radix = dec_end.radix;
         st.failed_flag = st.failed_flag | dec_end.fail;
         st = feed_held(st);
         st.char_position = rip_pkg::POS_DECIDED;
      end

      priority if (st.char_position == rip_pkg::POS_START || st.failed_flag ||
                   st.digit_count == 7'd0) begin
         status = rip_pkg::STATUS_FAIL;
      end else if (st.digit_count > digit_limit(st.effective_radix)) begin
         status = rip_pkg::STATUS_OVERFLOW;
      end else begin
         status = rip_pkg::STATUS_OK;
      end
   end

   assign result = '{parsed_value: st.accumulator, parse_status: status};
   assign result_valid = end_text;
   assign next_state = end_text ? rip_pkg::text_state_type'('0) : st;

endmodule

/* hw/rtl/radix_integer_parser.sv */
// Top level of the radix integer parser: input register, parse step, result register.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  rip_pkg::req_item_type, one character
//   rsp_      out        rsp_valid / rsp_stall  rip_pkg::rsp_item_type, one result per text
//   csr_      in         csr_valid / csr_ready  radix mode, 3 bits
//
// One item per cycle is accepted while req_stall is low; each text gives one registered result.
// The rate is set by the single parse step between the input and result registers.
// Reset is synchronous and clears the radix mode to auto and the text state.
// req_stall rises only when a text-ending item waits in the input register behind a
// stalled result; items that end no text keep flowing while a result waits.
`timescale 1ns / 1ps

module radix_integer_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rip_pkg::req_item_type   req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rip_pkg::rsp_item_type   rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  rip_pkg::radix_mode_type csr_wdata
);

   rip_pkg::radix_mode_type radix_mode_ff;
   logic                    in_valid_ff;
   logic                    in_valid_in;
   rip_pkg::req_item_type   in_item_ff;
   rip_pkg::text_state_type state_ff;
   rip_pkg::text_state_type state_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rip_pkg::rsp_item_type   rsp_item_ff;
   rip_pkg::rsp_item_type   step_result;
   logic                    step_result_valid;
   logic                    out_free;
   logic                    advance;
   logic                    req_accept;

   rip_step u_step (
      .radix_mode   (radix_mode_ff),
      .cur_state    (state_ff),
      .item         (in_item_ff),
      .next_state   (state_in),
      .result       (step_result),
      .result_valid (step_result_valid)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Items that end no text never wait for the result register.
   assign advance = in_valid_ff && (!step_result_valid || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_comb begin
      if (advance && step_result_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_mode_ff <= rip_pkg::MODE_AUTO;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= rip_pkg::text_state_type'('0);
      end else begin
         if (csr_valid) begin
            radix_mode_ff <= csr_wdata;
         end
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance && step_result_valid) begin
         rsp_item_ff <= step_result;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

/* hw/rtl/rip_checker.sv */
// Port-level checker for the radix integer parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rip_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input rip_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rip_pkg::rsp_item_type rsp_item
);

   // A stalled result stays offered.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid,
                   "rsp_valid dropped while stalled")

   // A stalled result keeps its payload.
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_item),
                   "rsp_item changed while stalled")

   // The input side is held back only by a waiting, stalled result.
   `ASSERT_CLK_RST(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall,
                   "req_stall without a stalled result")

   // A stalled input item stays offered and unchanged.
   `ASSERT_CLK_RST(a_req_hold, clock, reset,
                   req_valid && req_stall |=> req_valid && $stable(req_item),
                   "req item changed while stalled")

   // Reset leaves no result behind.
   `ASSERT_CLK(a_reset_clear, clock, reset |=> !rsp_valid && !req_stall,
               "output not cleared by reset")

endmodule

bind radix_integer_parser rip_checker u_rip_checker (.*);
